FILE: sv/matrix_row_sum_sorter_unit_defines.svh
// assertion macros used by the rtl
`ifndef MATRIX_ROW_SUM_SORTER_UNIT_DEFINES_SVH
`define MATRIX_ROW_SUM_SORTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MRSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MRSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/mrss_pkg.sv
package mrss_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int MAX_COLS  = 64;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int CNT_W     = 7;
	localparam int ELEM_W    = 32;
	localparam int SUM_W     = 38;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_USED,
		REG_COLS_USED
	} reg_idx_t;

	// microcode step labels
	typedef enum logic [3:0] {
		S_LOAD,
		S_INIT,
		S_IRD,
		S_ISUM,
		S_ILATCH,
		S_JRD,
		S_JSUM,
		S_CMP,
		S_IWB,
		S_ORST,
		S_ORD,
		S_OSUM,
		S_OPUT
	} ustep_t;

	typedef enum logic [1:0] {W_NONE, W_IN, W_OUT} hold_t;
	typedef enum logic [1:0] {ORD_RD_NONE, ORD_RD_I, ORD_RD_J} ord_rd_t;
	typedef enum logic [1:0] {OW_NONE, OW_INIT, OW_SWAP, OW_IWB} ord_wr_t;
	typedef enum logic [1:0] {A_NONE, A_ALWAYS, A_IF_GT} a_ld_t;
	typedef enum logic [1:0] {I_KEEP, I_CLR, I_INC} i_op_t;
	typedef enum logic [1:0] {J_KEEP, J_CLR, J_INC, J_FROM_I} j_op_t;
	typedef enum logic [2:0] {
		C_NONE,
		C_NOT_MAT_END,
		C_NOT_J_LAST,
		C_J_LAST,
		C_I_LAST,
		C_NOT_I_PENULT
	} cond_t;

	typedef struct packed {
		hold_t   hold;
		ord_rd_t ord_rd;
		logic    sum_rd;
		ord_wr_t ord_wr;
		a_ld_t   a_ld;
		i_op_t   i_op;
		j_op_t   j_op;
		cond_t   cond;
		ustep_t  next_s;
		ustep_t  jump_s;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '{
		hold:   W_NONE,
		ord_rd: ORD_RD_NONE,
		sum_rd: 1'b0,
		ord_wr: OW_NONE,
		a_ld:   A_NONE,
		i_op:   I_KEEP,
		j_op:   J_KEEP,
		cond:   C_NONE,
		next_s: S_LOAD,
		jump_s: S_LOAD
	};

	// control store: one word per step, jump_s taken when cond holds
	function automatic ctrl_t ucode(ustep_t s);
		ctrl_t c;
		c = CTRL_NOP;
		unique case (s)
			S_LOAD: begin
				c.hold   = W_IN;
				c.i_op   = I_CLR;
				c.j_op   = J_CLR;
				c.cond   = C_NOT_MAT_END;
				c.next_s = S_INIT;
				c.jump_s = S_LOAD;
			end
			S_INIT: begin
				c.ord_wr = OW_INIT;
				c.j_op   = J_INC;
				c.cond   = C_NOT_J_LAST;
				c.next_s = S_IRD;
				c.jump_s = S_INIT;
			end
			S_IRD: begin
				c.ord_rd = ORD_RD_I;
				c.next_s = S_ISUM;
			end
			S_ISUM: begin
				c.sum_rd = 1'b1;
				c.j_op   = J_FROM_I;
				c.next_s = S_ILATCH;
			end
			S_ILATCH: begin
				c.a_ld   = A_ALWAYS;
				c.cond   = C_I_LAST;
				c.next_s = S_JRD;
				c.jump_s = S_ORST;
			end
			S_JRD: begin
				c.ord_rd = ORD_RD_J;
				c.next_s = S_JSUM;
			end
			S_JSUM: begin
				c.sum_rd = 1'b1;
				c.next_s = S_CMP;
			end
			S_CMP: begin
				c.a_ld   = A_IF_GT;
				c.ord_wr = OW_SWAP;
				c.j_op   = J_INC;
				c.cond   = C_NOT_J_LAST;
				c.next_s = S_IWB;
				c.jump_s = S_JRD;
			end
			S_IWB: begin
				c.ord_wr = OW_IWB;
				c.i_op   = I_INC;
				c.cond   = C_NOT_I_PENULT;
				c.next_s = S_ORST;
				c.jump_s = S_IRD;
			end
			S_ORST: begin
				c.j_op   = J_CLR;
				c.next_s = S_ORD;
			end
			S_ORD: begin
				c.ord_rd = ORD_RD_J;
				c.next_s = S_OSUM;
			end
			S_OSUM: begin
				c.sum_rd = 1'b1;
				c.next_s = S_OPUT;
			end
			S_OPUT: begin
				c.hold   = W_OUT;
				c.j_op   = J_INC;
				c.cond   = C_J_LAST;
				c.next_s = S_ORD;
				c.jump_s = S_LOAD;
			end
			default: begin
				c.next_s = S_LOAD;
			end
		endcase
		return c;
	endfunction

	// zero counts as one, anything above the maximum as the maximum
	function automatic logic [CNT_W-1:0] clamp_cnt(logic [CNT_W-1:0] v,
		logic [CNT_W-1:0] maxv);
		logic [CNT_W-1:0] r;
		if (v == '0)
			r = CNT_W'(1);
		else if (v > maxv)
			r = maxv;
		else
			r = v;
		return r;
	endfunction

endpackage

FILE: sv/mrss_channels.sv
interface mrss_elem_if import mrss_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] element_value;

	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

interface mrss_row_if import mrss_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic        [ROW_W-1:0] source_row;
	logic signed [SUM_W-1:0] row_total;
	logic                    last_row;

	modport source (output valid, output source_row, output row_total, output last_row,
		input ready);
	modport sink (input valid, input source_row, input row_total, input last_row,
		output ready);
endinterface

interface mrss_cfg_if import mrss_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CNT_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/matrix_row_sum_sorter_unit.sv
// loading: elements are taken one per cycle while the sequencer waits in its load step;
// after the last element of a matrix the sequencer fills the row order and sorts it before
// the first row request; each row request reads the order memory, then the sum memory, and
// waits for room in the output register; one read port per memory sets the pace
// reset: load counters cleared, rows_used and cols_used set to 64, sequencer to load;
// the row sum and row order memories are not cleared
`include "matrix_row_sum_sorter_unit_defines.svh"

module matrix_row_sum_sorter_unit import mrss_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	mrss_cfg_if.sink   cfg,
	mrss_elem_if.sink  elem,
	mrss_row_if.source row_out
);

	// configuration registers
	logic [CNT_W-1:0] rows_used_q;
	logic [CNT_W-1:0] cols_used_q;

	// sequencer
	ustep_t upc_q;
	ustep_t upc_nxt;
	ctrl_t  cw;
	logic   go;
	logic   cond_hit;

	// load side
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] new_sum;
	logic [CNT_W-1:0] nrows_live;
	logic [CNT_W-1:0] ncols_live;
	logic             col_end;
	logic             row_end;
	logic             mat_end;
	logic             in_take;

	// sort side
	logic [CNT_W-1:0] nrows_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [ROW_W-1:0] a_q;
	logic [ROW_W-1:0] b_q;
	logic [SUM_W-1:0] suma_q;
	logic [ROW_W-1:0] ord_rd_q;
	logic [SUM_W-1:0] sum_rd_q;
	logic             gt;
	logic             j_last;
	logic             i_last;
	logic             i_penult;

	// order memory write port
	logic             ord_we;
	logic [ROW_W-1:0] ord_waddr;
	logic [ROW_W-1:0] ord_wdata;
	logic [ROW_W-1:0] ord_raddr;

	// memories
	logic [SUM_W-1:0] sum_mem [MAX_ROWS];
	logic [ROW_W-1:0] ord_mem [MAX_ROWS];

	// output register
	logic             out_valid_q;
	logic [ROW_W-1:0] out_row_q;
	logic [SUM_W-1:0] out_total_q;
	logic             out_last_q;
	logic             out_room;

	assign cfg.ready = 1'b1;

	// config registers; takes effect immediately
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_used_q <= CNT_W'(MAX_ROWS);
			cols_used_q <= CNT_W'(MAX_COLS);
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_ROWS_USED)
				rows_used_q <= cfg.data;
			else
				cols_used_q <= cfg.data;
		end
	end

	// fetch the control word of the current step
	assign cw = ucode(upc_q);

	assign out_room = !out_valid_q || row_out.ready;
	assign in_take  = elem.valid && elem.ready;

	// a step that waits on a channel does nothing until the channel moves
	always_comb begin
		case (cw.hold)
			W_IN:    go = elem.valid;
			W_OUT:   go = out_room;
			default: go = 1'b1;
		endcase
	end

	assign elem.ready = (cw.hold == W_IN);

	// element bookkeeping: the current row sum lives in acc_q, memory gets it at row end
	assign nrows_live = clamp_cnt(rows_used_q, CNT_W'(MAX_ROWS));
	assign ncols_live = clamp_cnt(cols_used_q, CNT_W'(MAX_COLS));
	assign col_end    = (CNT_W'(col_q) + CNT_W'(1)) >= ncols_live;
	assign row_end    = (CNT_W'(row_q) + CNT_W'(1)) >= nrows_live;
	assign mat_end    = col_end && row_end;

	always_comb begin
		if (col_q == '0)
			new_sum = {{(SUM_W-ELEM_W){elem.element_value[ELEM_W-1]}}, elem.element_value};
		else
			new_sum = acc_q + {{(SUM_W-ELEM_W){elem.element_value[ELEM_W-1]}},
				elem.element_value};
	end

	// sort conditions; the index tests are against the row count captured with the last load element
	assign gt       = $signed(suma_q) > $signed(sum_rd_q);
	assign j_last   = (j_q == nrows_q - CNT_W'(1));
	assign i_last   = (i_q == nrows_q - CNT_W'(1));
	assign i_penult = (i_q == nrows_q - CNT_W'(2));

	// branch unit
	always_comb begin
		case (cw.cond)
			C_NOT_MAT_END:  cond_hit = !mat_end;
			C_NOT_J_LAST:   cond_hit = !j_last;
			C_J_LAST:       cond_hit = j_last;
			C_I_LAST:       cond_hit = i_last;
			C_NOT_I_PENULT: cond_hit = !i_penult;
			default:        cond_hit = 1'b0;
		endcase
		if (!go)
			upc_nxt = upc_q;
		else if (cond_hit)
			upc_nxt = cw.jump_s;
		else
			upc_nxt = cw.next_s;
	end

	// order memory write: identity fill, swap of entry j, write-back of entry i
	always_comb begin
		ord_we    = 1'b0;
		ord_waddr = j_q[ROW_W-1:0];
		ord_wdata = a_q;
		case (cw.ord_wr)
			OW_INIT: begin
				ord_we    = go;
				ord_wdata = j_q[ROW_W-1:0];
			end
			OW_SWAP: begin
				ord_we = go && gt;
			end
			OW_IWB: begin
				ord_we    = go;
				ord_waddr = i_q[ROW_W-1:0];
			end
			default: begin
				ord_we = 1'b0;
			end
		endcase
	end

	assign ord_raddr = (cw.ord_rd == ORD_RD_I) ? i_q[ROW_W-1:0] : j_q[ROW_W-1:0];

	always_ff @(posedge clk) begin
		if (ord_we)
			ord_mem[ord_waddr] <= ord_wdata;
		if (go && cw.ord_rd != ORD_RD_NONE)
			ord_rd_q <= ord_mem[ord_raddr];
	end

	// sum memory: written at each row end, read at the row the order memory just gave
	always_ff @(posedge clk) begin
		if (in_take && col_end)
			sum_mem[row_q] <= new_sum;
		if (go && cw.sum_rd)
			sum_rd_q <= sum_mem[ord_rd_q];
	end

	// sequencer state, counters and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= S_LOAD;
			row_q       <= '0;
			col_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			nrows_q     <= CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_nxt;
			if (in_take) begin
				nrows_q <= nrows_live;
				col_q   <= col_end ? '0 : col_q + COL_W'(1);
				if (col_end)
					row_q <= row_end ? '0 : row_q + ROW_W'(1);
			end
			if (go) begin
				case (cw.i_op)
					I_CLR:   i_q <= '0;
					I_INC:   i_q <= i_q + CNT_W'(1);
					default: i_q <= i_q;
				endcase
				case (cw.j_op)
					J_CLR:    j_q <= '0;
					J_INC:    j_q <= j_q + CNT_W'(1);
					J_FROM_I: j_q <= i_q + CNT_W'(1);
					default:  j_q <= j_q;
				endcase
			end
			if (go && cw.hold == W_OUT)
				out_valid_q <= 1'b1;
			else if (row_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_take)
			acc_q <= new_sum;
		if (go && cw.sum_rd)
			b_q <= ord_rd_q;
		if (go && (cw.a_ld == A_ALWAYS || (cw.a_ld == A_IF_GT && gt))) begin
			a_q    <= b_q;
			suma_q <= sum_rd_q;
		end
		if (go && cw.hold == W_OUT) begin
			out_row_q   <= b_q;
			out_total_q <= sum_rd_q;
			out_last_q  <= j_last;
		end
	end

	assign row_out.valid      = out_valid_q;
	assign row_out.source_row = out_row_q;
	assign row_out.row_total  = out_total_q;
	assign row_out.last_row   = out_last_q;

	// the last element of a matrix hands over to the identity fill
	`MRSS_ASSERT_NEXT(a_end_to_init, in_take && mat_end, upc_q == S_INIT,
		"matrix end did not start the sort")
	// inner pass stays above i and inside the loaded rows
	`MRSS_ASSERT_NOW(a_cmp_range, upc_q == S_CMP, (i_q < j_q) && (j_q < nrows_q),
		"compare indices out of range")
	// every row request addresses a loaded row
	`MRSS_ASSERT_NOW(a_out_range, upc_q == S_OPUT, j_q < nrows_q,
		"row request beyond loaded rows")
	// captured row count is always a legal count once sorting starts
	`MRSS_ASSERT_NOW(a_nrows_ok, upc_q != S_LOAD,
		(nrows_q != '0) && (nrows_q <= CNT_W'(MAX_ROWS)), "row count out of range")

endmodule

FILE: dv/tb_matrix_row_sum_sorter_unit.sv
module tb_matrix_row_sum_sorter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mrss_pkg::*;

	// one entry of the sorted row order
	typedef struct {
		logic        [ROW_W-1:0] src;
		logic signed [SUM_W-1:0] total;
		logic                    last;
	} sorted_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mrss_cfg_if  cfg_ch ();
	mrss_elem_if elem_ch ();
	mrss_row_if  row_ch ();

	matrix_row_sum_sorter_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.elem    (elem_ch),
		.row_out (row_ch)
	);

	// shadow of the block: row sums, load position and the two registers
	logic signed [SUM_W-1:0] row_sum_mem [MAX_ROWS];
	logic        [ROW_W-1:0] load_row = '0;
	logic        [ROW_W-1:0] load_col = '0;
	logic        [CNT_W-1:0] rows_reg = CNT_W'(64);
	logic        [CNT_W-1:0] cols_reg = CNT_W'(64);

	// sorted rows still owed by the block, oldest first
	sorted_row_t sorted_q [$];

	int fail_count = 0;
	int rows_checked = 0;
	int elements_sent = 0;
	int matrices_done = 0;

	// set during the stretch where neither side idles
	bit no_gaps = 1'b0;

	always #2 clk = ~clk;

	// zero counts as one, anything above the ceiling as the ceiling
	function automatic int effective_count(logic [CNT_W-1:0] v, int ceiling);
		if (v == '0)
			return 1;
		if (int'(v) > ceiling)
			return ceiling;
		return int'(v);
	endfunction

	// mix of extremes, small values (equal sums) and full-range values
	function automatic logic signed [ELEM_W-1:0] random_element();
		logic signed [ELEM_W-1:0] e;
		case ($urandom_range(9))
			0: e = {1'b0, {(ELEM_W-1){1'b1}}};
			1: e = {1'b1, {(ELEM_W-1){1'b0}}};
			2: e = '1;
			3, 4, 5: e = $signed(ELEM_W'($urandom_range(16))) - 8;
			default: e = $urandom;
		endcase
		return e;
	endfunction

	// add one element into its row; after the last one, sort and queue the row order
	task automatic predict_element(input logic signed [ELEM_W-1:0] v);
		int nrows;
		int ncols;
		int r;
		int n;
		int tmp;
		int order [MAX_ROWS];
		logic signed [SUM_W-1:0] wide;
		sorted_row_t res;
		nrows = effective_count(rows_reg, MAX_ROWS);
		ncols = effective_count(cols_reg, MAX_COLS);
		wide = {{(SUM_W-ELEM_W){v[ELEM_W-1]}}, v};
		r = int'(load_row);
		// first element of a row replaces whatever sum was left there
		if (load_col == '0)
			row_sum_mem[r] = wide;
		else
			row_sum_mem[r] = row_sum_mem[r] + wide;
		if (int'(load_col) + 1 < ncols) begin
			load_col = ROW_W'(int'(load_col) + 1);
			return;
		end
		load_col = '0;
		if (r + 1 < nrows) begin
			load_row = ROW_W'(r + 1);
			return;
		end
		load_row = '0;
		// a lowered row count ends the matrix early, only loaded rows are sorted
		n = (r + 1 < nrows) ? r + 1 : nrows;
		for (int i = 0; i < n; i++)
			order[i] = i;
		// exchange sort, the row at i is looked at again after each swap
		for (int i = 0; i < n; i++) begin
			for (int j = i + 1; j < n; j++) begin
				if (row_sum_mem[order[i]] > row_sum_mem[order[j]]) begin
					tmp = order[i];
					order[i] = order[j];
					order[j] = tmp;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			res.src = ROW_W'(order[k]);
			res.total = row_sum_mem[order[k]];
			res.last = (k + 1 == n);
			sorted_q.push_back(res);
		end
		matrices_done++;
	endtask

	// element request, starts and ends on a falling edge
	task automatic send_element(input logic signed [ELEM_W-1:0] v);
		while (!no_gaps && $urandom_range(99) < 24) begin
			elem_ch.valid <= 1'b0;
			@(negedge clk);
		end
		elem_ch.valid <= 1'b1;
		elem_ch.element_value <= v;
		do
			@(posedge clk);
		while (!elem_ch.ready);
		predict_element(v);
		elements_sent++;
		@(negedge clk);
	endtask

	// register write, only called while the block is quiet
	task automatic write_register(input reg_idx_t idx, input int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= CNT_W'(value);
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		if (idx == REG_ROWS_USED)
			rows_reg = CNT_W'(value);
		else
			cols_reg = CNT_W'(value);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// drain all owed rows, then give a partial load time to settle
	task automatic wait_quiet();
		elem_ch.valid <= 1'b0;
		while (sorted_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_shape(input int rows, input int cols);
		wait_quiet();
		write_register(REG_ROWS_USED, rows);
		write_register(REG_COLS_USED, cols);
	endtask

	// one whole matrix of random content
	task automatic run_matrix(input int rows, input int cols);
		int count;
		set_shape(rows, cols);
		count = effective_count(CNT_W'(rows), MAX_ROWS) * effective_count(CNT_W'(cols), MAX_COLS);
		repeat (count) send_element(random_element());
	endtask

	// extremes of the element range, rows out of load order
	task automatic test_basic_order();
		set_shape(3, 2);
		send_element({1'b0, {(ELEM_W-1){1'b1}}});
		send_element({1'b0, {(ELEM_W-1){1'b1}}});
		send_element({1'b1, {(ELEM_W-1){1'b0}}});
		send_element({1'b1, {(ELEM_W-1){1'b0}}});
		send_element('0);
		send_element('1);
	endtask

	// equal sums, no swap when two sums are equal
	task automatic test_equal_sums();
		set_shape(4, 1);
		send_element(32'sd5);
		send_element(32'sd5);
		send_element(-32'sd3);
		send_element(32'sd5);
		set_shape(2, 2);
		send_element(32'sd1);
		send_element(32'sd2);
		send_element(32'sd2);
		send_element(32'sd1);
	endtask

	// zero acts as one, oversized values as the maximum; also the widest sum
	task automatic test_register_clamping();
		set_shape(0, 0);
		send_element(-32'sd7);
		set_shape(127, 1);
		repeat (MAX_ROWS) send_element(random_element());
		// full row of the largest element
		set_shape(1, 100);
		repeat (MAX_COLS) send_element({1'b0, {(ELEM_W-1){1'b1}}});
	endtask

	// register changes in the middle of a matrix take effect at once
	task automatic test_midload_change();
		set_shape(3, 4);
		repeat (3) send_element(random_element());
		// column counter already past the new limit, next element ends row 0
		wait_quiet();
		write_register(REG_COLS_USED, 2);
		repeat (4) send_element(random_element());
		// loader sits in row 2, next element ends the matrix with row 0 only
		wait_quiet();
		write_register(REG_ROWS_USED, 1);
		send_element(random_element());
	endtask

	// mostly small shapes, now and then a taller one
	task automatic test_random_matrices();
		int start;
		int rows;
		int cols;
		start = elements_sent;
		while (elements_sent - start < 50) begin
			// opening stretch with no idling on either side
			no_gaps = (elements_sent - start < 30);
			if ($urandom_range(9) == 0) begin
				rows = $urandom_range(9, 24);
				cols = $urandom_range(1, 2);
			end else begin
				rows = $urandom_range(1, 8);
				cols = $urandom_range(1, 8);
			end
			run_matrix(rows, cols);
		end
		no_gaps = 1'b0;
	endtask

	// result side, compares each accepted row with the oldest owed one
	always @(posedge clk) begin
		sorted_row_t want;
		if (arst_n && row_ch.valid && row_ch.ready) begin
			if (sorted_q.size() == 0) begin
				fail_count++;
				if (fail_count < 50)
					$display("%0t: unexpected row: row %0d total %0d last %0b", $time,
						row_ch.source_row, row_ch.row_total, row_ch.last_row);
			end else begin
				want = sorted_q.pop_front();
				rows_checked++;
				if (row_ch.source_row !== want.src || row_ch.row_total !== want.total ||
					row_ch.last_row !== want.last) begin
					fail_count++;
					if (fail_count < 50)
						$display("%0t: expected row %0d total %0d last %0b, got row %0d total %0d last %0b",
							$time, want.src, want.total, want.last,
							row_ch.source_row, row_ch.row_total, row_ch.last_row);
				end
			end
		end
	end

	// result side stalls at random outside the no-gap stretch
	always @(negedge clk)
		row_ch.ready <= no_gaps || ($urandom_range(99) >= 24);

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ROWS_USED;
		cfg_ch.data = '0;
		elem_ch.valid = 1'b0;
		elem_ch.element_value = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_order();
		test_equal_sums();
		test_register_clamping();
		test_midload_change();
		test_random_matrices();

		// drain, then a short tail to catch stray rows
		wait_quiet();
		repeat (20) @(posedge clk);

		$display("%0d elements in %0d matrices, %0d sorted rows checked",
			elements_sent, matrices_done, rows_checked);
		$display("shapes from 1x1 up to 64 rows or 64 columns, clamped registers, mid-load changes");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("timeout at %0t with %0d rows still owed", $time, sorted_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/mrss_pkg.sv
sv/mrss_channels.sv
sv/matrix_row_sum_sorter_unit.sv
dv/tb_matrix_row_sum_sorter_unit.sv
